// ===== rtl/lerg_pkg.sv =====
// Shared types and constants for the largest empty rectangle grid core.
// No dependencies.
`timescale 1ns / 1ps

package lerg_pkg;

    localparam int unsigned AREA_W   = 13;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned COORD_W  = 6;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    localparam logic MODE_MARK    = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_CLEAR = 7'b000_0010,
        S_ROW   = 7'b000_0100,
        S_HREAD = 7'b000_1000,
        S_CUR   = 7'b001_0000,
        S_CMP   = 7'b010_0000,
        S_POPW  = 7'b100_0000
    } t_state;

endpackage

// ===== rtl/largest_empty_rectangle_grid_core.sv =====
// Largest empty rectangle grid core: blocked map, column heights and a
// histogram stack held in synchronous memories. Depends on lerg_pkg.
`timescale 1ns / 1ps

//  channel  | dir | fields (lowest bit first)
//  s_axis   | in  | tdata: cell_row[5:0], cell_col[11:6], pad; tuser: mode
//  m_axis   | out | tdata: area[12:0], pad; tuser: status
//  cfg      | in  | i_cfg_we, i_cfg_index, i_cfg_data (row_count, col_count)
// A mark writes straight to the map. A compute runs, per row, a fetch of the map
// row, then a height read, a new height and a compare per column and for the
// closing column, and a pop step per pop, with at most cols pops a row; then
// the map is cleared, all MAX_ROWS rows. An error or a zero count goes straight
// to the clear. After reset the clearing pass holds s_axis_tready low. A result
// waiting in the output register holds the next compute at the last row of its
// clear, not the marks.
module largest_empty_rectangle_grid_core #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // cell_row, cell_col
    input  logic [0:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // area
    output logic [0:0]  m_axis_tuser,   // status
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [lerg_pkg::COUNT_W-1:0] i_cfg_data
);
    import lerg_pkg::*;

    localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CCW = $clog2(MAX_COLS + 1);
    localparam int unsigned HW  = RCW;
    localparam int unsigned PW  = HW + CCW;
    localparam int unsigned EW  = CCW + HW;   // stack entry: {column, height}

    // memories
    logic [MAX_COLS-1:0] m_map [MAX_ROWS];
    logic [HW-1:0]       m_hgt [MAX_COLS];
    logic [EW-1:0]       m_stk [MAX_COLS];

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_rows_cfg, r_cols_cfg;
    logic               r_err, r_emit;
    logic [RCW-1:0]     r_rows, r_r;
    logic [CCW-1:0]     r_cols, r_i;
    logic [CCW-1:0]     r_sp;
    logic [AREA_W-1:0]  r_best;
    logic [AREA_W-1:0]  r_res_area, r_area;
    logic               r_res_status, r_status, r_ovalid;
    logic [MAX_COLS-1:0] r_rowbits;
    logic [HW-1:0]      r_h, r_cur, r_hp, r_top_h;
    logic [EW-1:0]      r_sq;
    logic [PW-1:0]      r_prod;
    logic               r_pvalid;

    logic s_fire, m_fire;
    logic mode;
    logic [COORD_W-1:0] crow, ccol;
    logic [COUNT_W-1:0] rows_use, cols_use;
    logic mark_ok, start;
    logic [CW-1:0] col_ix;
    logic col_end;
    logic [HW-1:0] cur;
    logic do_pop;
    logic [CCW-1:0] sq_col;
    logic [HW-1:0]  sq_h;
    logic [CCW-1:0] pop_w;
    logic [CW-1:0]  stk_raddr;
    logic clr_last, clr_hold, out_load;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign mode = s_axis_tuser[0];
    assign crow = s_axis_tdata[5:0];
    assign ccol = s_axis_tdata[11:6];

    always_comb begin
        rows_use = (32'(r_rows_cfg) > MAX_ROWS) ? COUNT_W'(MAX_ROWS) : r_rows_cfg;
        cols_use = (32'(r_cols_cfg) > MAX_COLS) ? COUNT_W'(MAX_COLS) : r_cols_cfg;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_area};
    assign m_axis_tuser  = r_status;

    assign mark_ok = (COUNT_W'(crow) < rows_use) && (COUNT_W'(ccol) < cols_use);
    assign start   = s_fire && mode == MODE_COMPUTE;

    assign col_ix  = CW'(r_i);
    assign col_end = (r_i == r_cols);

    // new height of the current column; the closing column counts as zero
    always_comb begin
        if (col_end || r_rowbits[col_ix])
            cur = '0;
        else if (r_r == '0)
            cur = HW'(1);
        else
            cur = r_h + HW'(1);
    end

    assign do_pop    = (r_sp != '0) && (r_cur < r_top_h);
    assign sq_col    = r_sq[EW-1:HW];
    assign sq_h      = r_sq[HW-1:0];
    assign pop_w     = (r_sp == '0) ? r_i : r_i - sq_col - CCW'(1);
    // entry below the top, fetched while popping
    assign stk_raddr = (r_sp > CCW'(1)) ? CW'(r_sp - CCW'(2)) : '0;

    assign clr_last = (r_r == RCW'(MAX_ROWS - 1));
    assign clr_hold = r_emit && r_ovalid && !m_fire;
    assign out_load = (r_state == S_CLEAR) && clr_last && r_emit && !clr_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_rows_cfg <= COUNT_W'(64);
            r_cols_cfg <= COUNT_W'(64);
            r_err      <= 1'b0;
            r_emit     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_r        <= '0;
            r_pvalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= out_load || (r_ovalid && !m_fire);
            r_pvalid <= (r_state == S_POPW);
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ROWS) r_rows_cfg <= i_cfg_data;
                else                          r_cols_cfg <= i_cfg_data;
            end
            if (out_load) begin
                r_area   <= r_res_area;
                r_status <= r_res_status;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire && mode == MODE_MARK && !mark_ok) r_err <= 1'b1;
                    if (start) begin
                        r_rows       <= RCW'(rows_use);
                        r_cols       <= CCW'(cols_use);
                        r_best       <= '0;
                        r_r          <= '0;
                        r_emit       <= 1'b1;
                        r_err        <= 1'b0;
                        r_res_area   <= '0;
                        r_res_status <= (rows_use != '0 && cols_use != '0 && r_err) ?
                                        STATUS_ERR : STATUS_OK;
                    end
                end
                S_CLEAR: begin
                    if (!clr_last) r_r <= r_r + RCW'(1);
                    else if (!clr_hold) r_emit <= 1'b0;
                end
                S_ROW: begin
                    r_i  <= '0;
                    r_sp <= '0;
                    if (r_r == r_rows) begin
                        r_r          <= '0;
                        r_res_area   <= r_best;
                        r_res_status <= STATUS_OK;
                    end
                end
                S_HREAD: ;
                S_CUR: begin
                    r_cur <= cur;
                end
                S_CMP: begin
                    if (r_pvalid) begin
                        if (32'(r_prod) > 32'(AREA_MAX)) r_best <= AREA_MAX;
                        else if (AREA_W'(r_prod) > r_best) r_best <= AREA_W'(r_prod);
                    end
                    if (do_pop) begin
                        r_hp <= r_top_h;
                        r_sp <= r_sp - CCW'(1);
                    end else if (col_end) begin
                        r_r <= r_r + RCW'(1);
                    end else begin
                        r_top_h <= r_cur;
                        r_sp    <= r_sp + CCW'(1);
                        r_i     <= r_i + CCW'(1);
                    end
                end
                S_POPW: begin
                    if (r_sp != '0) r_top_h <= sq_h;
                    r_prod <= PW'(r_hp) * PW'(pop_w);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start)
                         n_state = ((rows_use == '0) || (cols_use == '0) || r_err) ?
                                   S_CLEAR : S_ROW;
            S_CLEAR: if (clr_last && !clr_hold) n_state = S_IDLE;
            S_ROW:   n_state = (r_r == r_rows) ? S_CLEAR : S_HREAD;
            S_HREAD: n_state = S_CUR;
            S_CUR:   n_state = S_CMP;
            S_CMP:   if (do_pop)       n_state = S_POPW;
                     else if (col_end) n_state = S_ROW;
                     else              n_state = S_HREAD;
            S_POPW:  n_state = S_CMP;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // map: clear pass writes rows, mark writes one bit, row step reads
        if (r_state == S_CLEAR)
            m_map[RW'(r_r)] <= '0;
        else if (s_fire && mode == MODE_MARK && mark_ok)
            m_map[RW'(crow)][CW'(ccol)] <= 1'b1;
        if (r_state == S_ROW)
            r_rowbits <= m_map[RW'(r_r)];
        // heights: read on the visit, write back the new height
        if (r_state == S_CUR && !col_end)
            m_hgt[col_ix] <= cur;
        r_h <= m_hgt[col_ix];
        // stack: push column and height; the top is also held in r_top_h
        if (r_state == S_CMP && !do_pop && !col_end)
            m_stk[CW'(r_sp)] <= {r_i, r_cur};
        r_sq <= m_stk[stk_raddr];
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
    a_err_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[12:0] == '0)
        else $error("error with nonzero area");

endmodule
